>>> sv/tcpca_pkg.sv
// Shared types, codes and transition tables for the TCP state machine
// with challenge ACK rate limiting. No dependencies.
`default_nettype none

package tcpca_pkg;

    localparam int NUM_STATES = 10;
    localparam int NUM_EVENTS = 6;

    // Connection states
    localparam logic [3:0] ST_LISTEN      = 4'd0;
    localparam logic [3:0] ST_SYN_RCVD    = 4'd1;
    localparam logic [3:0] ST_ESTAB       = 4'd2;
    localparam logic [3:0] ST_CLOSE_WAIT  = 4'd3;
    localparam logic [3:0] ST_LAST_ACK    = 4'd4;
    localparam logic [3:0] ST_FIN_WAIT1   = 4'd5;
    localparam logic [3:0] ST_FIN_WAIT2   = 4'd6;
    localparam logic [3:0] ST_CLOSING     = 4'd7;
    localparam logic [3:0] ST_TIME_WAIT   = 4'd8;
    localparam logic [3:0] ST_CLOSED      = 4'd9;

    // Segment events
    localparam logic [2:0] SEG_SYN   = 3'd0;
    localparam logic [2:0] SEG_ACK   = 3'd1;
    localparam logic [2:0] SEG_FIN   = 3'd2;
    localparam logic [2:0] SEG_RST   = 3'd3;
    localparam logic [2:0] SEG_DATA  = 3'd4;
    localparam logic [2:0] SEG_CLOSE = 3'd5;

    // Responses
    localparam logic [2:0] RSP_SILENT  = 3'd0;
    localparam logic [2:0] RSP_SYN_ACK = 3'd1;
    localparam logic [2:0] RSP_ACK     = 3'd2;
    localparam logic [2:0] RSP_RST     = 3'd3;
    localparam logic [2:0] RSP_FIN_ACK = 3'd4;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAL_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_ON_RST = 2'd2;

    localparam logic [7:0]  LIMIT_RESET  = 8'd10;
    localparam logic [19:0] WINDOW_RESET = 20'd5000;

    typedef struct packed {
        logic [2:0]  segment;
        logic [15:0] elapsed;
        logic        restart_first;
    } t_in;

    typedef struct packed {
        logic [2:0] response;
        logic [3:0] next_conn_state;
        logic       is_challenge;
        logic       suppressed;
    } t_out;

    typedef struct packed {
        logic [7:0]  limit;
        logic [19:0] window;
        logic        clear_on_restart;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  count;
        logic        open;
        logic [19:0] ticks;
    } t_lim;

    typedef logic [0:NUM_EVENTS-1][3:0] t_nxt_row;
    typedef logic [0:NUM_EVENTS-1][2:0] t_rsp_row;

    // Next state, columns SYN ACK FIN RST DATA CLOSE
    localparam t_nxt_row NXT_TAB [0:NUM_STATES-1] = '{
        '{ST_SYN_RCVD, ST_LISTEN, ST_LISTEN, ST_LISTEN, ST_LISTEN, ST_CLOSED},
        '{ST_SYN_RCVD, ST_ESTAB, ST_CLOSE_WAIT, ST_LISTEN, ST_SYN_RCVD, ST_FIN_WAIT1},
        '{ST_ESTAB, ST_ESTAB, ST_CLOSE_WAIT, ST_CLOSED, ST_ESTAB, ST_FIN_WAIT1},
        '{ST_CLOSE_WAIT, ST_CLOSE_WAIT, ST_CLOSE_WAIT, ST_CLOSED, ST_CLOSE_WAIT,
          ST_LAST_ACK},
        '{ST_LAST_ACK, ST_CLOSED, ST_LAST_ACK, ST_CLOSED, ST_LAST_ACK, ST_LAST_ACK},
        '{ST_FIN_WAIT1, ST_FIN_WAIT2, ST_CLOSING, ST_CLOSED, ST_FIN_WAIT1,
          ST_FIN_WAIT1},
        '{ST_FIN_WAIT2, ST_FIN_WAIT2, ST_TIME_WAIT, ST_CLOSED, ST_FIN_WAIT2,
          ST_FIN_WAIT2},
        '{ST_CLOSING, ST_TIME_WAIT, ST_CLOSING, ST_CLOSED, ST_CLOSING, ST_CLOSING},
        '{ST_TIME_WAIT, ST_TIME_WAIT, ST_TIME_WAIT, ST_TIME_WAIT, ST_TIME_WAIT,
          ST_TIME_WAIT},
        '{ST_CLOSED, ST_CLOSED, ST_CLOSED, ST_CLOSED, ST_CLOSED, ST_CLOSED}
    };

    // Response, same layout
    localparam t_rsp_row RSP_TAB [0:NUM_STATES-1] = '{
        '{RSP_SYN_ACK, RSP_RST, RSP_SILENT, RSP_SILENT, RSP_RST, RSP_SILENT},
        '{RSP_SILENT, RSP_SILENT, RSP_ACK, RSP_SILENT, RSP_SILENT, RSP_FIN_ACK},
        '{RSP_ACK, RSP_SILENT, RSP_ACK, RSP_SILENT, RSP_ACK, RSP_FIN_ACK},
        '{RSP_ACK, RSP_SILENT, RSP_ACK, RSP_SILENT, RSP_ACK, RSP_FIN_ACK},
        '{RSP_ACK, RSP_SILENT, RSP_ACK, RSP_SILENT, RSP_SILENT, RSP_SILENT},
        '{RSP_ACK, RSP_SILENT, RSP_ACK, RSP_SILENT, RSP_ACK, RSP_SILENT},
        '{RSP_ACK, RSP_SILENT, RSP_ACK, RSP_SILENT, RSP_ACK, RSP_SILENT},
        '{RSP_ACK, RSP_SILENT, RSP_ACK, RSP_SILENT, RSP_SILENT, RSP_SILENT},
        '{RSP_ACK, RSP_SILENT, RSP_ACK, RSP_SILENT, RSP_SILENT, RSP_SILENT},
        '{RSP_RST, RSP_RST, RSP_RST, RSP_SILENT, RSP_RST, RSP_SILENT}
    };

endpackage

`default_nettype wire

>>> sv/tcp_state_with_challenge_ack_limit.sv
// TCP connection state machine with challenge ACK rate limiting.
// Input transfer to result valid passes an input register, then a result
// register. Throughput: one item per cycle while the output is not stalled; the connection
// and limiter state update in the single cycle an item moves to the result.
// Reset (synchronous, active low) empties both registers, returns to listen,
// clears the limiter and loads the default configuration.
`default_nettype none

module tcp_state_with_challenge_ack_limit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // item input
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire tcpca_pkg::t_in                    i_in,
    // result output
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output tcpca_pkg::t_out                        o_out,
    // configuration writes
    input  wire logic                              i_cfg_we,
    input  wire logic [tcpca_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [tcpca_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import tcpca_pkg::*;

    logic       r_in_valid;
    t_in        r_in;
    logic       r_out_valid;
    t_out       r_out;
    logic [3:0] r_conn;
    t_lim       r_lim;
    t_cfg       r_cfg;

    logic       w_out_free;
    logic       w_move;
    t_lim       n_lim;
    t_out       n_out;

    // Handshake: result register frees when empty or taken
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_move      = r_in_valid && w_out_free;
    assign o_in_stall  = r_in_valid && !w_out_free;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    tcpca_step u_step (
        .i_conn (r_conn),
        .i_lim  (r_lim),
        .i_cfg  (r_cfg),
        .i_item (r_in),
        .o_lim  (n_lim),
        .o_res  (n_out)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in;
        end
    end

    // Result register and machine state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_conn      <= ST_LISTEN;
            r_lim       <= '0;
        end else begin
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (w_move) begin
                r_conn <= n_out.next_conn_state;
                r_lim  <= n_lim;
            end
        end
        if (w_move) begin
            r_out <= n_out;
        end
    end

    // Configuration registers; unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.limit            <= LIMIT_RESET;
            r_cfg.window           <= WINDOW_RESET;
            r_cfg.clear_on_restart <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CHAL_LIMIT:   r_cfg.limit            <= i_cfg_wdata[7:0];
                CFG_WINDOW_TICKS: r_cfg.window           <= i_cfg_wdata[19:0];
                CFG_CLEAR_ON_RST: r_cfg.clear_on_restart <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Checks
    a_sup_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.suppressed |->
            r_out.is_challenge && (r_out.response == RSP_SILENT))
        else $error("suppressed result is not a silent challenge");

    a_state_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.next_conn_state <= ST_CLOSED))
        else $error("next connection state out of range");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_move |=> $stable(r_conn) && $stable(r_lim))
        else $error("machine state changed without an item");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid && !r_in_valid)
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

>>> sv/tcpca_step.sv
// One step of the connection machine and the challenge ACK limiter.
// Pure combinational; depends on tcpca_pkg.
`default_nettype none

module tcpca_step (
    input  wire logic [3:0]     i_conn,
    input  wire tcpca_pkg::t_lim i_lim,
    input  wire tcpca_pkg::t_cfg i_cfg,
    input  wire tcpca_pkg::t_in  i_item,
    output tcpca_pkg::t_lim      o_lim,
    output tcpca_pkg::t_out      o_res
);
    import tcpca_pkg::*;

    logic        clr;
    logic [3:0]  conn0;
    t_lim        lim0;
    logic [20:0] sum;
    logic [19:0] ticks1;
    logic        seg_ok;
    logic        chal;
    logic        expired;

    // Restart and limiter clear
    always_comb begin
        clr   = i_item.restart_first & i_cfg.clear_on_restart;
        conn0 = i_item.restart_first ? ST_LISTEN : i_conn;
        if (conn0 > ST_CLOSED) begin
            conn0 = ST_LISTEN;
        end
        lim0 = clr ? '0 : i_lim;
    end

    // Window age, saturating at the window length
    always_comb begin
        sum = {1'b0, lim0.ticks} + {5'd0, i_item.elapsed};
        if (!lim0.open) begin
            ticks1 = lim0.ticks;
        end else if (sum > {1'b0, i_cfg.window}) begin
            ticks1 = i_cfg.window;
        end else begin
            ticks1 = sum[19:0];
        end
    end

    // Table lookup and challenge handling
    always_comb begin
        seg_ok  = i_item.segment < 3'(NUM_EVENTS);
        chal    = seg_ok && (i_item.segment == SEG_SYN)
                  && (conn0 >= ST_ESTAB) && (conn0 <= ST_TIME_WAIT);
        expired = !lim0.open || (ticks1 >= i_cfg.window);

        o_res.response        = RSP_SILENT;
        o_res.next_conn_state = conn0;
        o_res.is_challenge    = chal;
        o_res.suppressed      = 1'b0;
        o_lim.count           = lim0.count;
        o_lim.open            = lim0.open;
        o_lim.ticks           = ticks1;

        if (seg_ok) begin
            o_res.response        = RSP_TAB[conn0][i_item.segment];
            o_res.next_conn_state = NXT_TAB[conn0][i_item.segment];
        end

        if (chal) begin
            priority if (expired) begin
                o_lim.open  = 1'b1;
                o_lim.ticks = '0;
                o_lim.count = 8'd1;
            end else if (lim0.count < i_cfg.limit) begin
                o_lim.count = lim0.count + 8'd1;
            end else begin
                o_res.response   = RSP_SILENT;
                o_res.suppressed = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking bench for the TCP connection state machine with challenge ACK limiting.
// Holds a cycle-free predictor of the table and limiter and a result scoreboard.
// Depends on tcpca_pkg and tcp_state_with_challenge_ack_limit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcpca_pkg::*;

    // Segment codes outside the table; the block must leave the state alone
    localparam logic [2:0] SEG_RSVD6 = 3'd6;
    localparam logic [2:0] SEG_RSVD7 = 3'd7;
    // Register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 86;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in i_in = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out o_out;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // Predicted configuration and connection/limiter state
    logic [7:0] cfg_limit = LIMIT_RESET;
    logic [19:0] cfg_window = WINDOW_RESET;
    logic cfg_clear = 1'b0;
    logic [3:0] pred_conn = ST_LISTEN;
    logic [7:0] pred_count = '0;
    logic pred_open = 1'b0;
    logic [19:0] pred_ticks = '0;

    t_out expected_replies[$];
    int mismatch_count = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    bit in_pace = 1'b0;
    bit out_pace = 1'b0;

    tcp_state_with_challenge_ack_limit i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in(i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out(o_out),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Transition table: returns {response, next state}
    function automatic logic [6:0] lookup_move(input logic [3:0] st, input logic [2:0] seg);
        logic [0:5][3:0] nrow;
        logic [0:5][2:0] rrow;
        case (st)
            ST_SYN_RCVD: begin
                nrow = {ST_SYN_RCVD, ST_ESTAB, ST_CLOSE_WAIT, ST_LISTEN, ST_SYN_RCVD,
                        ST_FIN_WAIT1};
                rrow = {RSP_SILENT, RSP_SILENT, RSP_ACK, RSP_SILENT, RSP_SILENT, RSP_FIN_ACK};
            end
            ST_ESTAB: begin
                nrow = {ST_ESTAB, ST_ESTAB, ST_CLOSE_WAIT, ST_CLOSED, ST_ESTAB, ST_FIN_WAIT1};
                rrow = {RSP_ACK, RSP_SILENT, RSP_ACK, RSP_SILENT, RSP_ACK, RSP_FIN_ACK};
            end
            ST_CLOSE_WAIT: begin
                nrow = {ST_CLOSE_WAIT, ST_CLOSE_WAIT, ST_CLOSE_WAIT, ST_CLOSED, ST_CLOSE_WAIT,
                        ST_LAST_ACK};
                rrow = {RSP_ACK, RSP_SILENT, RSP_ACK, RSP_SILENT, RSP_ACK, RSP_FIN_ACK};
            end
            ST_LAST_ACK: begin
                nrow = {ST_LAST_ACK, ST_CLOSED, ST_LAST_ACK, ST_CLOSED, ST_LAST_ACK,
                        ST_LAST_ACK};
                rrow = {RSP_ACK, RSP_SILENT, RSP_ACK, RSP_SILENT, RSP_SILENT, RSP_SILENT};
            end
            ST_FIN_WAIT1: begin
                nrow = {ST_FIN_WAIT1, ST_FIN_WAIT2, ST_CLOSING, ST_CLOSED, ST_FIN_WAIT1,
                        ST_FIN_WAIT1};
                rrow = {RSP_ACK, RSP_SILENT, RSP_ACK, RSP_SILENT, RSP_ACK, RSP_SILENT};
            end
            ST_FIN_WAIT2: begin
                nrow = {ST_FIN_WAIT2, ST_FIN_WAIT2, ST_TIME_WAIT, ST_CLOSED, ST_FIN_WAIT2,
                        ST_FIN_WAIT2};
                rrow = {RSP_ACK, RSP_SILENT, RSP_ACK, RSP_SILENT, RSP_ACK, RSP_SILENT};
            end
            ST_CLOSING: begin
                nrow = {ST_CLOSING, ST_TIME_WAIT, ST_CLOSING, ST_CLOSED, ST_CLOSING,
                        ST_CLOSING};
                rrow = {RSP_ACK, RSP_SILENT, RSP_ACK, RSP_SILENT, RSP_SILENT, RSP_SILENT};
            end
            ST_TIME_WAIT: begin
                nrow = {6{ST_TIME_WAIT}};
                rrow = {RSP_ACK, RSP_SILENT, RSP_ACK, RSP_SILENT, RSP_SILENT, RSP_SILENT};
            end
            ST_CLOSED: begin
                nrow = {6{ST_CLOSED}};
                rrow = {RSP_RST, RSP_RST, RSP_RST, RSP_SILENT, RSP_RST, RSP_SILENT};
            end
            default: begin
                nrow = {ST_SYN_RCVD, ST_LISTEN, ST_LISTEN, ST_LISTEN, ST_LISTEN, ST_CLOSED};
                rrow = {RSP_SYN_ACK, RSP_RST, RSP_SILENT, RSP_SILENT, RSP_RST, RSP_SILENT};
            end
        endcase
        return {rrow[seg], nrow[seg]};
    endfunction

    // Advance the predicted connection by one segment and return its reply
    function automatic t_out step_connection(input t_in it);
        t_out r;
        logic [20:0] sum;
        r = '0;
        if (it.restart_first) begin
            pred_conn = ST_LISTEN;
            if (cfg_clear) begin
                pred_count = '0;
                pred_open = 1'b0;
                pred_ticks = '0;
            end
        end
        if (pred_conn > ST_CLOSED) pred_conn = ST_LISTEN;
        // time only runs once a window is anchored, saturating at the window
        if (pred_open) begin
            sum = pred_ticks + it.elapsed;
            pred_ticks = (sum > cfg_window) ? cfg_window : sum[19:0];
        end
        r.next_conn_state = pred_conn;
        if (it.segment <= SEG_CLOSE) begin
            {r.response, r.next_conn_state} = lookup_move(pred_conn, it.segment);
            // SYN in a synchronized state is a challenge ACK
            if (it.segment == SEG_SYN && pred_conn >= ST_ESTAB && pred_conn <= ST_TIME_WAIT) begin
                r.is_challenge = 1'b1;
                if (!pred_open || pred_ticks >= cfg_window) begin
                    pred_open = 1'b1;
                    pred_ticks = '0;
                    pred_count = 8'd1;
                end else if (pred_count < cfg_limit) begin
                    pred_count = pred_count + 8'd1;
                end else begin
                    r.response = RSP_SILENT;
                    r.suppressed = 1'b1;
                end
            end
        end
        pred_conn = r.next_conn_state;
        return r;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic t_in segment_item(input logic [2:0] seg, input logic [15:0] el,
                                         input logic rst);
        t_in it;
        it.segment = seg;
        it.elapsed = el;
        it.restart_first = rst;
        return it;
    endfunction

    // Random segment steered by the predicted state so sessions get established
    function automatic t_in make_item();
        t_in it;
        int r;
        int cap;
        r = $urandom_range(0, 99);
        it.restart_first = 1'b0;
        it.segment = 3'($urandom_range(SEG_SYN, SEG_CLOSE));
        case (pred_conn)
            ST_LISTEN: if (r < 70) it.segment = SEG_SYN;
            ST_SYN_RCVD: if (r < 70) it.segment = SEG_ACK;
            ST_TIME_WAIT, ST_CLOSED: begin
                if (r < 40) begin
                    it.restart_first = 1'b1;
                    it.segment = SEG_SYN;
                end
            end
            default: if (r < 45) it.segment = SEG_SYN;
        endcase
        // noise: undefined segment codes and stray restarts
        r = $urandom_range(0, 99);
        if (r < 4) it.segment = r[0] ? SEG_RSVD7 : SEG_RSVD6;
        else if (r < 8) it.restart_first = 1'b1;
        cap = (cfg_window >> 2) + 1;
        if (cap > 65535) cap = 65535;
        r = $urandom_range(0, 99);
        if (r < 35) it.elapsed = '0;
        else if (r < 65) it.elapsed = 16'($urandom_range(0, cap));
        else if (r < 90) it.elapsed = 16'($urandom);
        else it.elapsed = '1;
        return it;
    endfunction

    // Append one predicted reply to the scoreboard
    task automatic queue_reply(input t_out r);
        expected_replies = {expected_replies, r};
    endtask

    // One input transfer; the reply is predicted when the transfer happens
    task automatic send_item(input t_in it);
        int gap;
        i_in <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        queue_reply(step_connection(it));
        gap = in_pace ? pick_gap() : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drain all replies, then allow the pipeline to settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            CFG_CHAL_LIMIT: cfg_limit = val[7:0];
            CFG_WINDOW_TICKS: cfg_window = val[19:0];
            CFG_CLEAR_ON_RST: cfg_clear = val[0];
            default: ;
        endcase
    endtask

    // Rewrite all registers while idle; a write to the spare index must be ignored
    task automatic configure(input logic [7:0] limit, input logic [19:0] window,
                             input logic clear);
        wait_idle();
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        write_reg(CFG_CHAL_LIMIT, CFG_DATA_W'(limit));
        write_reg(CFG_WINDOW_TICKS, window);
        write_reg(CFG_CLEAR_ON_RST, CFG_DATA_W'(clear));
        i_cfg_we <= 1'b0;
    endtask

    // Walk the table under reset configuration: every segment, absorbing states
    task automatic test_table_walk();
        send_item(segment_item(SEG_SYN, 16'hFFFF, 1'b0));   // no window yet
        send_item(segment_item(SEG_ACK, 16'h0000, 1'b0));
        send_item(segment_item(SEG_SYN, 16'h0000, 1'b0));   // opens a window
        send_item(segment_item(SEG_SYN, 16'hFFFF, 1'b0));   // window expired
        send_item(segment_item(SEG_RSVD6, 16'h5555, 1'b0));
        send_item(segment_item(SEG_RSVD7, 16'hAAAA, 1'b0));
        send_item(segment_item(SEG_DATA, 16'h0001, 1'b0));
        send_item(segment_item(SEG_FIN, 16'h0000, 1'b0));
        send_item(segment_item(SEG_CLOSE, 16'h0000, 1'b0));
        send_item(segment_item(SEG_ACK, 16'h0000, 1'b0));
        send_item(segment_item(SEG_SYN, 16'h0000, 1'b0));   // reset from closed
        send_item(segment_item(SEG_SYN, 16'h0000, 1'b1));
        send_item(segment_item(SEG_CLOSE, 16'h0000, 1'b0));
        send_item(segment_item(SEG_ACK, 16'h0000, 1'b0));
        send_item(segment_item(SEG_FIN, 16'h0000, 1'b0));
        send_item(segment_item(SEG_SYN, 16'h0000, 1'b0));   // challenge in time-wait
        send_item(segment_item(SEG_RST, 16'h0000, 1'b1));
    endtask

    // Zero limit: only the opening challenge of each window is answered
    task automatic test_limit_zero();
        configure(8'd0, 20'd1000, 1'b0);
        send_item(segment_item(SEG_SYN, 16'h0000, 1'b0));
        send_item(segment_item(SEG_ACK, 16'h0000, 1'b0));
        send_item(segment_item(SEG_SYN, 16'hFFFF, 1'b0));
        send_item(segment_item(SEG_SYN, 16'h0000, 1'b0));
        send_item(segment_item(SEG_SYN, 16'd999, 1'b0));
        send_item(segment_item(SEG_SYN, 16'd1, 1'b0));      // exactly at the window end
    endtask

    // Zero window: every challenge opens a fresh window
    task automatic test_window_zero();
        configure(8'd2, 20'd0, 1'b0);
        send_item(segment_item(SEG_SYN, 16'h0000, 1'b0));
        send_item(segment_item(SEG_SYN, 16'h0000, 1'b0));
    endtask

    // Window shrunk below the accumulated ticks counts as expired
    task automatic test_window_shrink();
        configure(8'd255, 20'hFFFFF, 1'b0);
        send_item(segment_item(SEG_SYN, 16'h0000, 1'b0));
        send_item(segment_item(SEG_SYN, 16'd50000, 1'b0));
        configure(8'd255, 20'd100, 1'b0);
        send_item(segment_item(SEG_SYN, 16'h0000, 1'b0));
    endtask

    // Restart with clearing enabled drops the limiter history
    task automatic test_clear_on_restart();
        configure(8'd1, 20'hFFFFF, 1'b1);
        send_item(segment_item(SEG_SYN, 16'h0000, 1'b1));
        send_item(segment_item(SEG_ACK, 16'h0000, 1'b0));
        send_item(segment_item(SEG_SYN, 16'h0000, 1'b0));
        send_item(segment_item(SEG_SYN, 16'h0000, 1'b0));
    endtask

    // Random sessions across several configurations and pacing mixes
    task automatic test_random_traffic();
        int p;
        for (p = 0; p < 6; p++) begin
            case (p)
                0: configure(8'd10, 20'd5000, 1'b0);
                1: configure(8'd0, 20'd1, 1'b1);
                2: configure(8'd255, 20'hFFFFF, 1'b0);
                3: configure(8'd3, 20'd300, 1'b1);
                4: configure(8'd1, 20'hFFFF, 1'b0);
                default: configure(8'($urandom_range(0, 8)), 20'($urandom_range(1, 20000)),
                                   1'($urandom_range(0, 1)));
            endcase
            in_pace = (p != 1 && p != 4);
            out_pace = (p != 2 && p != 4);
            repeat (ITEMS_PER_PHASE) send_item(make_item());
        end
    endtask

    // Output back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n || !out_pace) begin
            i_out_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin : stall_pick
            int n;
            n = pick_gap();
            i_out_stall <= (n != 0);
            stall_left <= (n != 0) ? n - 1 : 0;
        end
    end

    task automatic flag_field(input string name, input int want, input int got);
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        mismatch_count++;
    endtask

    // Compare every reply transfer against the oldest prediction
    always @(posedge i_clk) begin : reply_check
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_replies.size() == 0) begin
                $display("%0t: unexpected reply, expected none actual %h", $time, o_out);
                mismatch_count++;
            end else begin
                want = expected_replies.pop_front();
                if (o_out.response !== want.response)
                    flag_field("response", want.response, o_out.response);
                if (o_out.next_conn_state !== want.next_conn_state)
                    flag_field("next_conn_state", want.next_conn_state, o_out.next_conn_state);
                if (o_out.is_challenge !== want.is_challenge)
                    flag_field("is_challenge", want.is_challenge, o_out.is_challenge);
                if (o_out.suppressed !== want.suppressed)
                    flag_field("suppressed", want.suppressed, o_out.suppressed);
            end
        end
    end

    // Watchdog: too long without any transfer or register write
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        in_pace = 1'b1;
        out_pace = 1'b1;
        test_table_walk();
        test_limit_zero();
        test_window_zero();
        test_window_shrink();
        test_clear_on_restart();
        test_random_traffic();
        wait_idle();
        if (mismatch_count == 0 && expected_replies.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
